/* hdl/sexpr_token_lexer_macros.svh */
// Assertion macros shared by the lexer checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SEXPR_TOKEN_LEXER_MACROS_SVH
`define SEXPR_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define STL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define STL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/stl_pkg.sv */
// Package for the s-expression token lexer: widths, codes and shared types.
// Depends on nothing; used by the channel interfaces, the lexer core and the top level.
package stl_pkg;

   localparam int LINE_BITS   = 20;
   localparam int NUMBER_BITS = 32;
   localparam int MAX_EVENTS  = 3;

   // Characters the lexer reacts to
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_TICK      = 8'h27;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0] LINE_LIMIT = {LINE_BITS{1'b1}};

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_MINUS   = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_ESCAPE  = 3'd4,
      MODE_IDENT   = 3'd5,
      MODE_COMMENT = 3'd6
   } lexer_mode_type;

   typedef enum logic [2:0] {
      TOK_LPAREN = 3'd0,
      TOK_RPAREN = 3'd1,
      TOK_NUMBER = 3'd2,
      TOK_SBYTE  = 3'd3,
      TOK_SEND   = 3'd4,
      TOK_IBYTE  = 3'd5,
      TOK_IEND   = 3'd6,
      TOK_UNTERM = 3'd7
   } token_kind_type;

   typedef struct packed {
      lexer_mode_type         mode;
      logic [NUMBER_BITS-1:0] acc;
      logic                   neg;
      logic [LINE_BITS-1:0]   line;
   } lex_state_type;

   typedef struct packed {
      token_kind_type         kind;
      logic [7:0]             text;
      logic [NUMBER_BITS-1:0] num;
   } lex_event_type;

   typedef struct packed {
      lex_state_type                     state;
      lex_event_type [MAX_EVENTS-1:0]    events;
      logic [1:0]                        count;
   } lex_step_type;

endpackage

/* hdl/stl_channels_if.sv */
// Valid/ready channel interfaces for the lexer: source bytes in, token items out.
// Depends on stl_pkg for the payload widths.
interface stl_req_if
   import stl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] input_byte;
   logic       end_of_input;

   modport source (output valid, output input_byte, output end_of_input, input ready);
   modport sink   (input valid, input input_byte, input end_of_input, output ready);
endinterface

interface stl_rsp_if
   import stl_pkg::*;
   ();
   logic                          valid;
   logic                          ready;
   logic [2:0]                    token_kind;
   logic [7:0]                    byte_value;
   logic signed [NUMBER_BITS-1:0] number_value;
   logic [LINE_BITS-1:0]          line_number;
   logic                          last_of_run;

   modport source (output valid, output token_kind, output byte_value, output number_value,
                   output line_number, output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input byte_value, input number_value,
                   input line_number, input last_of_run, output ready);
endinterface

/* hdl/stl_lex_core.sv */
// Lexer step: next state and up to three token events for one source byte.
// Depends on stl_pkg; purely combinational, driven from the top level's registers.
module stl_lex_core
   import stl_pkg::*;
   (
   input  lex_state_type state,
   input  logic [7:0]    in_byte,
   input  logic          in_eoi,
   output lex_step_type  step
   );

   logic                   is_digit;
   logic                   is_space;
   logic                   is_delim;
   logic [NUMBER_BITS-1:0] digit_ext;
   logic [NUMBER_BITS-1:0] acc_times_ten;
   logic [NUMBER_BITS-1:0] number_out;

   // Classify the byte
   assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign is_space  = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
   assign is_delim  = is_space || (in_byte == CH_LPAREN) || (in_byte == CH_RPAREN)
                      || (in_byte == CH_TICK);
   assign digit_ext = NUMBER_BITS'(in_byte - CH_ZERO) & NUMBER_BITS'(4'hF);

   // acc * 10 as two shifted adds, wrapping at the number width
   assign acc_times_ten = {state.acc[NUMBER_BITS-4:0], 3'b000}
                          + {state.acc[NUMBER_BITS-2:0], 1'b0};
   assign number_out    = state.neg ? (NUMBER_BITS'(0) - state.acc) : state.acc;

   always_comb begin
      lexer_mode_type mode;
      logic           again;
      logic [1:0]     n;

      step        = '0;
      step.state  = state;
      mode        = state.mode;
      again       = 1'b1;
      n           = 2'd0;

      if (in_eoi) begin
         // Flush the pending token, then restart at line one
         case (state.mode)
            MODE_MINUS: begin
               step.events[0] = '{kind: TOK_IBYTE, text: CH_MINUS, num: '0};
               step.events[1] = '{kind: TOK_IEND, text: 8'h00, num: '0};
               n = 2'd2;
            end
            MODE_NUMBER: begin
               step.events[0] = '{kind: TOK_NUMBER, text: 8'h00, num: number_out};
               n = 2'd1;
            end
            MODE_ESCAPE: begin
               step.events[0] = '{kind: TOK_SBYTE, text: CH_BACKSLASH, num: '0};
               step.events[1] = '{kind: TOK_UNTERM, text: 8'h00, num: '0};
               n = 2'd2;
            end
            MODE_STRING: begin
               step.events[0] = '{kind: TOK_UNTERM, text: 8'h00, num: '0};
               n = 2'd1;
            end
            MODE_IDENT: begin
               step.events[0] = '{kind: TOK_IEND, text: 8'h00, num: '0};
               n = 2'd1;
            end
            default: begin
               n = 2'd0;
            end
         endcase
         step.state.mode = MODE_IDLE;
         step.state.acc  = '0;
         step.state.neg  = 1'b0;
         step.state.line = LINE_FIRST;
      end else begin
         // Up to three passes: a byte that ends a token is lexed again
         for (int p = 0; p < MAX_EVENTS; p++) begin
            if (again) begin
               again = 1'b0;
               case (mode)
                  MODE_MINUS: begin
                     if (is_digit) begin
                        step.state.acc = digit_ext;
                        step.state.neg = 1'b1;
                        mode = MODE_NUMBER;
                     end else begin
                        step.events[n] = '{kind: TOK_IBYTE, text: CH_MINUS, num: '0};
                        n = n + 2'd1;
                        mode = MODE_IDENT;
                        again = 1'b1;
                     end
                  end
                  MODE_NUMBER: begin
                     if (is_digit) begin
                        step.state.acc = acc_times_ten + digit_ext;
                     end else begin
                        step.events[n] = '{kind: TOK_NUMBER, text: 8'h00, num: number_out};
                        n = n + 2'd1;
                        mode = MODE_IDLE;
                        again = 1'b1;
                     end
                  end
                  MODE_ESCAPE: begin
                     mode = MODE_STRING;
                     if (in_byte == CH_LOWER_N) begin
                        step.events[n] = '{kind: TOK_SBYTE, text: CH_NEWLINE, num: '0};
                     end else if (in_byte == CH_QUOTE) begin
                        step.events[n] = '{kind: TOK_SBYTE, text: CH_QUOTE, num: '0};
                     end else begin
                        step.events[n] = '{kind: TOK_SBYTE, text: CH_BACKSLASH, num: '0};
                        again = 1'b1;
                     end
                     n = n + 2'd1;
                  end
                  MODE_STRING: begin
                     if (in_byte == CH_QUOTE) begin
                        step.events[n] = '{kind: TOK_SEND, text: 8'h00, num: '0};
                        n = n + 2'd1;
                        mode = MODE_IDLE;
                     end else if (in_byte == CH_BACKSLASH) begin
                        mode = MODE_ESCAPE;
                     end else begin
                        step.events[n] = '{kind: TOK_SBYTE, text: in_byte, num: '0};
                        n = n + 2'd1;
                     end
                  end
                  MODE_IDENT: begin
                     if (is_delim) begin
                        step.events[n] = '{kind: TOK_IEND, text: 8'h00, num: '0};
                        n = n + 2'd1;
                        mode = MODE_IDLE;
                        again = 1'b1;
                     end else begin
                        step.events[n] = '{kind: TOK_IBYTE, text: in_byte, num: '0};
                        n = n + 2'd1;
                     end
                  end
                  MODE_COMMENT: begin
                     if (in_byte == CH_NEWLINE) begin
                        mode = MODE_IDLE;
                     end
                  end
                  default: begin
                     mode = MODE_IDLE;
                     if (in_byte == CH_LPAREN) begin
                        step.events[n] = '{kind: TOK_LPAREN, text: 8'h00, num: '0};
                        n = n + 2'd1;
                     end else if (in_byte == CH_RPAREN) begin
                        step.events[n] = '{kind: TOK_RPAREN, text: 8'h00, num: '0};
                        n = n + 2'd1;
                     end else if (is_space) begin
                        mode = MODE_IDLE;
                     end else if (in_byte == CH_SEMICOLON) begin
                        mode = MODE_COMMENT;
                     end else if (in_byte == CH_MINUS) begin
                        mode = MODE_MINUS;
                     end else if (is_digit) begin
                        step.state.acc = digit_ext;
                        step.state.neg = 1'b0;
                        mode = MODE_NUMBER;
                     end else if (in_byte == CH_QUOTE) begin
                        mode = MODE_STRING;
                     end else begin
                        step.events[n] = '{kind: TOK_IBYTE, text: in_byte, num: '0};
                        n = n + 2'd1;
                        mode = MODE_IDENT;
                     end
                  end
               endcase
            end
         end
         step.state.mode = mode;
         // Count the newline once, after its events, and hold at the top
         if ((in_byte == CH_NEWLINE) && (state.line != LINE_LIMIT)) begin
            step.state.line = state.line + LINE_BITS'(1);
         end
      end
      step.count = n;
   end

endmodule

/* hdl/sexpr_token_lexer.sv */
// Top level of the s-expression token lexer: input register, lexer step, result buffer.
// Depends on stl_pkg, the channel interfaces in stl_channels_if.sv and stl_lex_core.
//
// Use: source bytes enter on req_ch, one item per byte; an item with end_of_input set
// carries no byte and flushes the pending token, then restarts the lexer at line 1.
// Each item yields zero to three token items on rsp_ch; the last one of an item has
// last_of_run set. Items that yield nothing (whitespace, comment text, digits inside a
// number) leave no trace on rsp_ch but still advance the lexer state.
// Path: an accepted byte waits in the input register until the result buffer is free;
// its token items are then loaded into the result buffer, which shows the first one
// on rsp_ch, where it can be taken.
// Throughput: one byte per cycle while each byte yields at most one token item and
// rsp_ch is ready; a byte that yields more holds the input until the result buffer has
// drained them, one token item per cycle while rsp_ch is ready, through the single rsp_ch port.
// Stall: while rsp_ch is not ready, the current token item is held; one more byte is
// taken into the input register and then req_ch.ready drops until the buffer frees.
// Reset: synchronous, active high; clears the buffer, the input register valid, and
// returns the lexer to idle at line 1 with the number accumulator at zero.
module sexpr_token_lexer
   import stl_pkg::*;
   (
   input logic      clock,
   input logic      reset,
   stl_req_if.sink  req_ch,
   stl_rsp_if.source rsp_ch
   );

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [7:0]                     in_byte_ff;
   logic                           in_eoi_ff;
   lex_state_type                  state_ff;
   lex_step_type                   step;
   lex_event_type [MAX_EVENTS-1:0] events_ff;
   logic [LINE_BITS-1:0]           line_ff;
   logic [1:0]                     count_ff;
   logic [1:0]                     count_in;
   logic [1:0]                     idx_ff;
   logic [1:0]                     idx_in;
   logic                           buf_free;
   logic                           consume;
   logic                           load;
   lex_event_type                  cur_event;

   stl_lex_core u_core (
      .state   (state_ff),
      .in_byte (in_byte_ff),
      .in_eoi  (in_eoi_ff),
      .step    (step)
   );

   // The buffer frees when empty or when its last token item is taken now
   assign buf_free      = (idx_ff == count_ff)
                          || (((idx_ff + 2'd1) == count_ff) && rsp_ch.ready);
   assign consume       = in_valid_ff && buf_free;
   assign load          = consume && (step.count != 2'd0);
   assign req_ch.ready  = !in_valid_ff || buf_free;
   assign in_valid_in   = req_ch.valid || (in_valid_ff && !consume);

   // Advance the drain pointer, or reload from a finished step
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      if (consume) begin
         idx_in   = 2'd0;
         count_in = step.count;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         idx_ff         <= 2'd0;
         count_ff       <= 2'd0;
         state_ff.mode  <= MODE_IDLE;
         state_ff.acc   <= '0;
         state_ff.neg   <= 1'b0;
         state_ff.line  <= LINE_FIRST;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= in_valid_in;
         end
         idx_ff   <= idx_in;
         count_ff <= count_in;
         if (consume) begin
            state_ff <= step.state;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.input_byte;
         in_eoi_ff  <= req_ch.end_of_input;
      end
      if (load) begin
         events_ff <= step.events;
         line_ff   <= state_ff.line;
      end
   end

   // Present the token item under the drain pointer
   assign cur_event           = events_ff[idx_ff];
   assign rsp_ch.valid        = (idx_ff != count_ff);
   assign rsp_ch.token_kind   = cur_event.kind;
   assign rsp_ch.byte_value   = cur_event.text;
   assign rsp_ch.number_value = $signed(cur_event.num);
   assign rsp_ch.line_number  = line_ff;
   assign rsp_ch.last_of_run  = ((idx_ff + 2'd1) == count_ff);

endmodule

/* hdl/stl_checker.sv */
// Port-level checker for the s-expression token lexer, bound to the top level.
// Depends on stl_pkg and sexpr_token_lexer_macros.svh.
`include "sexpr_token_lexer_macros.svh"

module stl_checker
   import stl_pkg::*;
   (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    token_kind,
   input logic [7:0]                    byte_value,
   input logic signed [NUMBER_BITS-1:0] number_value,
   input logic [LINE_BITS-1:0]          line_number,
   input logic                          last_of_run
   );

   // A stalled token item stays put
   `STL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(token_kind) && $stable(byte_value) && $stable(number_value) && $stable(line_number) && $stable(last_of_run), "stalled token item changed")

   // Nothing is offered right after reset
   `STL_ASSERT_IMPL(a_reset_empty, clock, reset, $fell(reset), !rsp_valid, "token item right after reset")

   // Only number tokens carry a value
   `STL_ASSERT_IMPL(a_num_zero, clock, reset, rsp_valid && (token_kind != TOK_NUMBER), number_value == '0, "value on a non-number token")

   // Only string and identifier bytes carry text
   `STL_ASSERT_IMPL(a_text_zero, clock, reset, rsp_valid && (token_kind != TOK_SBYTE) && (token_kind != TOK_IBYTE), byte_value == 8'h00, "text on a non-byte token")

   // Lines count from one
   `STL_ASSERT_IMPL(a_line_nonzero, clock, reset, rsp_valid, line_number != '0, "line number zero")

endmodule

bind sexpr_token_lexer stl_checker u_stl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .token_kind   (rsp_ch.token_kind),
   .byte_value   (rsp_ch.byte_value),
   .number_value (rsp_ch.number_value),
   .line_number  (rsp_ch.line_number),
   .last_of_run  (rsp_ch.last_of_run)
);

/* test/tb_sexpr_token_lexer.sv */
// Self-checking testbench for sexpr_token_lexer: drives source bytes and checks token items.
// Depends on stl_pkg, the channel interfaces in stl_channels_if.sv and the lexer top level.
module tb_sexpr_token_lexer;
   import stl_pkg::*;

   localparam int IDLE_LIMIT = 500;
   localparam int TARGET_ITEMS = 400;
   localparam int MISMATCH_SHOWN = 10;

   // One expected token item
   typedef struct {
      token_kind_type         kind;
      logic [7:0]             text;
      logic [NUMBER_BITS-1:0] num;
      logic [LINE_BITS-1:0]   line;
      logic                   last;
   } token_item_type;

   // Lexer predictor plus the queue of token items still to arrive
   class token_scoreboard;
      lexer_mode_type         mode;
      logic [NUMBER_BITS-1:0] acc;
      logic                   neg;
      logic [LINE_BITS-1:0]   line;
      token_item_type         expected_tokens[$];
      token_item_type         burst[$];
      int                     mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         mode = MODE_IDLE;
         acc  = '0;
         neg  = 1'b0;
         line = LINE_FIRST;
      endfunction

      function bit is_blank(logic [7:0] b);
         return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= CH_ZERO && b <= CH_NINE;
      endfunction

      // Drop events beyond the per-item maximum
      function void add_token(token_kind_type k, logic [7:0] t, logic [NUMBER_BITS-1:0] n);
         token_item_type it;
         if (burst.size() >= MAX_EVENTS) return;
         it.kind = k;
         it.text = t;
         it.num  = n;
         it.line = line;
         it.last = 1'b0;
         burst.push_back(it);
      endfunction

      function void add_number();
         logic [NUMBER_BITS-1:0] v;
         v = neg ? -acc : acc;
         add_token(TOK_NUMBER, 8'h00, v);
      endfunction

      // Lex one byte in the current mode; return 1 when it must be lexed again
      function bit lex_char(logic [7:0] b);
         case (mode)
            MODE_MINUS: begin
               if (is_digit(b)) begin
                  acc  = NUMBER_BITS'(b - CH_ZERO);
                  neg  = 1'b1;
                  mode = MODE_NUMBER;
                  return 1'b0;
               end
               add_token(TOK_IBYTE, CH_MINUS, '0);
               mode = MODE_IDENT;
               return 1'b1;
            end
            MODE_NUMBER: begin
               if (is_digit(b)) begin
                  acc = acc * 10 + NUMBER_BITS'(b - CH_ZERO);
                  return 1'b0;
               end
               add_number();
               mode = MODE_IDLE;
               return 1'b1;
            end
            MODE_ESCAPE: begin
               mode = MODE_STRING;
               if (b == CH_LOWER_N) begin
                  add_token(TOK_SBYTE, CH_NEWLINE, '0);
                  return 1'b0;
               end
               if (b == CH_QUOTE) begin
                  add_token(TOK_SBYTE, CH_QUOTE, '0);
                  return 1'b0;
               end
               add_token(TOK_SBYTE, CH_BACKSLASH, '0);
               return 1'b1;
            end
            MODE_STRING: begin
               if (b == CH_QUOTE) begin
                  add_token(TOK_SEND, 8'h00, '0);
                  mode = MODE_IDLE;
               end else if (b == CH_BACKSLASH) begin
                  mode = MODE_ESCAPE;
               end else begin
                  add_token(TOK_SBYTE, b, '0);
               end
               return 1'b0;
            end
            MODE_IDENT: begin
               if (is_blank(b) || b == CH_LPAREN || b == CH_RPAREN || b == CH_TICK) begin
                  add_token(TOK_IEND, 8'h00, '0);
                  mode = MODE_IDLE;
                  return 1'b1;
               end
               add_token(TOK_IBYTE, b, '0);
               return 1'b0;
            end
            MODE_COMMENT: begin
               if (b == CH_NEWLINE) mode = MODE_IDLE;
               return 1'b0;
            end
            default: begin
               mode = MODE_IDLE;
               if (b == CH_LPAREN) add_token(TOK_LPAREN, 8'h00, '0);
               else if (b == CH_RPAREN) add_token(TOK_RPAREN, 8'h00, '0);
               else if (is_blank(b)) mode = MODE_IDLE;
               else if (b == CH_SEMICOLON) mode = MODE_COMMENT;
               else if (b == CH_MINUS) mode = MODE_MINUS;
               else if (is_digit(b)) begin
                  acc  = NUMBER_BITS'(b - CH_ZERO);
                  neg  = 1'b0;
                  mode = MODE_NUMBER;
               end else if (b == CH_QUOTE) mode = MODE_STRING;
               else begin
                  add_token(TOK_IBYTE, b, '0);
                  mode = MODE_IDENT;
               end
               return 1'b0;
            end
         endcase
      endfunction

      // Predict the token items of one accepted source item
      function void note_input(logic [7:0] b, logic eoi);
         token_item_type tail;
         burst.delete();
         if (eoi) begin
            case (mode)
               MODE_MINUS: begin
                  add_token(TOK_IBYTE, CH_MINUS, '0);
                  add_token(TOK_IEND, 8'h00, '0);
               end
               MODE_NUMBER: add_number();
               MODE_ESCAPE: begin
                  add_token(TOK_SBYTE, CH_BACKSLASH, '0);
                  add_token(TOK_UNTERM, 8'h00, '0);
               end
               MODE_STRING: add_token(TOK_UNTERM, 8'h00, '0);
               MODE_IDENT:  add_token(TOK_IEND, 8'h00, '0);
               default: ;
            endcase
            restart();
         end else begin
            for (int pass = 0; pass < MAX_EVENTS; pass++) begin
               if (!lex_char(b)) break;
            end
            // Count the newline after its events, saturating
            if (b == CH_NEWLINE && line != LINE_LIMIT) line = line + 1'b1;
         end
         if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
         end
         foreach (burst[i]) expected_tokens.push_back(burst[i]);
      endfunction

      // Compare one accepted token item with the oldest expectation
      function void check_result(logic [2:0] kind, logic [7:0] text,
                                 logic [NUMBER_BITS-1:0] num, logic [LINE_BITS-1:0] ln,
                                 logic last);
         token_item_type want;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("unexpected token item: kind=%0d byte=%h num=%h line=%0d last=%b",
                        kind, text, num, ln, last);
            return;
         end
         want = expected_tokens.pop_front();
         if (kind !== want.kind || text !== want.text || num !== want.num ||
             ln !== want.line || last !== want.last) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("token mismatch: expected kind=%0d byte=%h num=%h line=%0d last=%b, %s",
                        want.kind, want.text, want.num, want.line, want.last,
                        $sformatf("got kind=%0d byte=%h num=%h line=%0d last=%b",
                                  kind, text, num, ln, last));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   no_idle;
   int   sent_items;
   int   stall_left;
   int   idle_cycles;
   string ident_chars = "abqxyz?!*+<=>_/.-09";
   token_scoreboard board;

   stl_req_if req_ch ();
   stl_rsp_if rsp_ch ();

   sexpr_token_lexer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one source item, wait for its handshake, then idle a random gap
   task automatic send_item(input logic [7:0] b, input logic eoi);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.input_byte   <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      board.note_input(b, eoi);
      sent_items++;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // Hold the source until every expected token item has come
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.expected_tokens.size() != 0) @(posedge clock);
   endtask

   // Accept and check token items, stalling a random number of cycles after each
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         board.check_result(rsp_ch.token_kind, rsp_ch.byte_value, rsp_ch.number_value,
                            rsp_ch.line_number, rsp_ch.last_of_run);
         stall_left = no_idle ? 0 : $urandom_range(0, 8);
         if (stall_left > 0) rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // End the run after too many cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int pick;
      int k;
      bit drained;
      board = new();
      reset = 1'b1;
      no_idle = 1'b0;
      drained = 1'b0;
      sent_items = 0;
      req_ch.valid        <= 1'b0;
      req_ch.input_byte   <= 8'h00;
      req_ch.end_of_input <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: parens, negative number, lone minus before a tick, ident end
      send_text("(-7-')");
      // Escapes: newline, quote, other byte, then a backslash pending at end of input
      send_text("\"\\n\\\"\\q\\");
      send_item(8'h5A, 1'b1);
      // Comment swallowing byte 255, newline, then 255 as an identifier
      send_text(";");
      send_item(8'hFF, 1'b0);
      send_item(CH_NEWLINE, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      // Flush a lone minus, a number and an open string
      send_text("-");
      send_item(8'hFF, 1'b1);
      send_text("9");
      send_item(8'h00, 1'b1);
      send_text("\"");
      send_item(8'hA5, 1'b1);
      drain_results();

      // Random token fragments with noise, flushes and separators
      while (sent_items < TARGET_ITEMS) begin
         if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
         if (!drained && sent_items > TARGET_ITEMS / 2) begin
            drain_results();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            if ($urandom_range(0, 1)) send_item(CH_MINUS, 1'b0);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            repeat (n) send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
         end else if (pick < 38) begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(ident_chars[$urandom_range(0, ident_chars.len() - 1)], 1'b0);
         end else if (pick < 56) begin
            send_item(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) begin
               k = $urandom_range(0, 5);
               case (k)
                  0: begin
                     send_item(CH_BACKSLASH, 1'b0);
                     send_item(CH_LOWER_N, 1'b0);
                  end
                  1: begin
                     send_item(CH_BACKSLASH, 1'b0);
                     send_item(CH_QUOTE, 1'b0);
                  end
                  2: begin
                     send_item(CH_BACKSLASH, 1'b0);
                     send_item(8'($urandom), 1'b0);
                  end
                  default: send_item(8'($urandom_range(32, 126)), 1'b0);
               endcase
            end
            if ($urandom_range(0, 9) != 0) send_item(CH_QUOTE, 1'b0);
         end else if (pick < 70) begin
            send_item($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN, 1'b0);
         end else if (pick < 80) begin
            send_item(($urandom_range(0, 5) == 5) ? CH_SPACE : 8'($urandom_range(9, 13)), 1'b0);
         end else if (pick < 86) begin
            send_item(CH_SEMICOLON, 1'b0);
            n = $urandom_range(0, 5);
            repeat (n) send_item(8'($urandom_range(32, 126)), 1'b0);
            send_item(CH_NEWLINE, 1'b0);
         end else if (pick < 91) begin
            send_item(8'($urandom), 1'b1);
         end else begin
            send_item(8'($urandom), 1'b0);
         end
         if ($urandom_range(0, 9) < 6)
            send_item(($urandom_range(0, 2) == 0) ? CH_NEWLINE : CH_SPACE, 1'b0);
      end

      // Wait for the tail, then watch for stray token items
      drain_results();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.expected_tokens.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
